// ===== design/ffba_pkg.sv =====
// shared types and constants of the first-fit block allocator
package ffba_pkg;

  localparam int MAX_BLOCKS    = 64;
  localparam int GRANULE_SHIFT = 12;
  localparam int AW            = $clog2(MAX_BLOCKS);
  localparam int CW            = $clog2(MAX_BLOCKS + 1);

  localparam logic [32:0] GRAN_MASK = 33'((64'd1 << GRANULE_SHIFT) - 64'd1);

  localparam logic [7:0] REG_POOL_BASE  = 8'd0;
  localparam logic [7:0] REG_POOL_BYTES = 8'd1;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREEH = 2'd1;
  localparam logic [1:0] MODE_FREEO = 2'd2;
  localparam logic [1:0] MODE_INFO  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        in_use;
    logic [4:0]  owner;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_addr;
    logic [31:0] granted_bytes;
    logic [15:0] granted_handle;
    logic [31:0] bytes_used;
    logic [31:0] pool_total;
  } res_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] request_bytes;
    logic [4:0]  owner_id;
    logic [15:0] block_handle;
  } req_t;

endpackage

// ===== design/ffba_ram.sv =====
// generic single-clock ram with one write port and one registered read port
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ffba_ctrl.sv =====
// sequencer that scans, splits, frees and merges the block table in ram
module ffba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ffba_pkg::req_t        req_i,
  input  logic                  rebuild_i,
  output logic                  idle_o,
  input  logic [31:0]           pool_base_i,
  input  logic [31:0]           pool_bytes_i,
  output logic                  we_o,
  output logic [ffba_pkg::AW-1:0] waddr_o,
  output ffba_pkg::entry_t      wdata_o,
  output logic [ffba_pkg::AW-1:0] raddr_o,
  input  ffba_pkg::entry_t      rdata_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ffba_pkg::res_t        res_o
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_REBUILD, S_IDLE, S_SCAN, S_SHIFT, S_WRHI, S_WRLO, S_MERGE, S_FLUSH, S_RESP
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d, iss_q, iss_d, chk_q, chk_d, fi_q, fi_d, w_q, w_d;
  logic        rv_q, rv_d, found_q, found_d, cv_q, cv_d, byh_q, byh_d;
  logic [31:0] used_q, used_d, size_q, size_d;
  logic [15:0] nh_q, nh_d, key_q, key_d;
  logic [4:0]  owner_q, owner_d;
  entry_t      fe_q, fe_d, cur_q, cur_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] addr_q, addr_d, bytes_q, bytes_d, total_q, total_d;
  logic [15:0] hout_q, hout_d;

  always_comb begin
    logic [32:0] rs;
    logic [32:0] base;
    logic [32:0] offs;
    logic [33:0] lim;
    logic [31:0] len;
    logic        match;
    entry_t      em;
    state_d  = state_q;
    count_d  = count_q;
    iss_d    = iss_q;
    chk_d    = chk_q;
    fi_d     = fi_q;
    w_d      = w_q;
    rv_d     = rv_q;
    found_d  = found_q;
    cv_d     = cv_q;
    byh_d    = byh_q;
    used_d   = used_q;
    size_d   = size_q;
    nh_d     = nh_q;
    key_d    = key_q;
    owner_d  = owner_q;
    fe_d     = fe_q;
    cur_d    = cur_q;
    status_d = status_q;
    addr_d   = addr_q;
    bytes_d  = bytes_q;
    total_d  = total_q;
    hout_d   = hout_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = '0;
    raddr_o  = iss_q[AW-1:0];
    rs       = '0;
    base     = '0;
    offs     = '0;
    lim      = '0;
    len      = '0;
    match    = 1'b0;
    em       = rdata_i;
    case (state_q)
      S_REBUILD: begin
        base = ({1'b0, pool_base_i} + GRAN_MASK) & ~GRAN_MASK;
        offs = base - {1'b0, pool_base_i};
        if (!base[32] && offs < {1'b0, pool_bytes_i}) begin
          len = pool_bytes_i - offs[31:0];
          lim = {1'b0, base} + {2'b0, len};
          if (lim > 34'h1_0000_0000) begin
            len = 32'd0 - base[31:0];
          end
        end
        we_o     = 1'b1;
        waddr_o  = '0;
        wdata_o  = '{start: base[31:0], length: len, in_use: 1'b0, owner: '0, handle: '0};
        count_d  = CW'(1);
        used_d   = '0;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (rebuild_i) begin
          state_d = S_REBUILD;
        end else if (req_valid_i) begin
          addr_d  = '0;
          bytes_d = '0;
          hout_d  = '0;
          total_d = '0;
          found_d = 1'b0;
          iss_d   = '0;
          rv_d    = 1'b0;
          w_d     = '0;
          cv_d    = 1'b0;
          owner_d = req_i.owner_id;
          case (req_i.mode)
            MODE_ALLOC: begin
              rs = ({1'b0, req_i.request_bytes} + GRAN_MASK) & ~GRAN_MASK;
              size_d = rs[31:0];
              if (rs == '0 || rs[32]) begin
                status_d = ST_NOFIT;
                state_d  = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_FREEH: begin
              byh_d   = 1'b1;
              key_d   = req_i.block_handle;
              state_d = S_MERGE;
            end
            MODE_FREEO: begin
              byh_d   = 1'b0;
              key_d   = {11'd0, req_i.owner_id};
              state_d = S_MERGE;
            end
            default: begin
              total_d  = pool_bytes_i;
              status_d = ST_OK;
              state_d  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_q < count_q) begin
          rv_d  = 1'b1;
          chk_d = iss_q;
          iss_d = iss_q + CW'(1);
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          if (!rdata_i.in_use && rdata_i.length >= size_q) begin
            fe_d  = rdata_i;
            fi_d  = chk_q;
            iss_d = count_q;
            rv_d  = 1'b0;
            if (rdata_i.length > size_q) begin
              if (count_q >= CW'(MAX_BLOCKS)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                state_d = S_SHIFT;
              end
            end else begin
              state_d = S_WRLO;
            end
          end else if (chk_q == count_q - CW'(1)) begin
            status_d = ST_NOFIT;
            state_d  = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        if (rv_q) begin
          we_o    = 1'b1;
          waddr_o = chk_q[AW-1:0];
          wdata_o = rdata_i;
        end
        if (iss_q > fi_q + CW'(1)) begin
          raddr_o = AW'(iss_q - CW'(1));
          chk_d   = iss_q;
          iss_d   = iss_q - CW'(1);
          rv_d    = 1'b1;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            state_d = S_WRHI;
          end
        end
      end
      S_WRHI: begin
        we_o    = 1'b1;
        waddr_o = AW'(fi_q + CW'(1));
        wdata_o = '{start: fe_q.start + size_q, length: fe_q.length - size_q,
                    in_use: 1'b0, owner: '0, handle: '0};
        count_d = count_q + CW'(1);
        state_d = S_WRLO;
      end
      S_WRLO: begin
        we_o     = 1'b1;
        waddr_o  = fi_q[AW-1:0];
        wdata_o  = '{start: fe_q.start, length: size_q, in_use: 1'b1,
                     owner: owner_q, handle: nh_q};
        used_d   = used_q + size_q;
        addr_d   = fe_q.start;
        bytes_d  = size_q;
        hout_d   = nh_q;
        nh_d     = (nh_q == 16'hFFFF) ? 16'd1 : nh_q + 16'd1;
        status_d = ST_OK;
        state_d  = S_RESP;
      end
      S_MERGE: begin
        if (iss_q < count_q) begin
          rv_d  = 1'b1;
          chk_d = iss_q;
          iss_d = iss_q + CW'(1);
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          match = rdata_i.in_use && key_q != '0 && !(byh_q && found_q) &&
                  (byh_q ? (rdata_i.handle == key_q)
                         : ({11'd0, rdata_i.owner} == key_q));
          if (match) begin
            em.in_use = 1'b0;
            em.owner  = '0;
            em.handle = '0;
            used_d    = used_q - rdata_i.length;
            found_d   = 1'b1;
          end
          if (cv_q && !cur_q.in_use && !em.in_use) begin
            cur_d.length = cur_q.length + em.length;
          end else begin
            if (cv_q) begin
              we_o    = 1'b1;
              waddr_o = w_q[AW-1:0];
              wdata_o = cur_q;
              w_d     = w_q + CW'(1);
            end
            cur_d = em;
            cv_d  = 1'b1;
          end
          if (chk_q == count_q - CW'(1)) begin
            rv_d    = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        we_o     = 1'b1;
        waddr_o  = w_q[AW-1:0];
        wdata_o  = cur_q;
        count_d  = w_q + CW'(1);
        status_d = found_q ? ST_OK : ST_NOTFOUND;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_REBUILD;
      count_q  <= CW'(1);
      iss_q    <= '0;
      chk_q    <= '0;
      fi_q     <= '0;
      w_q      <= '0;
      rv_q     <= 1'b0;
      found_q  <= 1'b0;
      cv_q     <= 1'b0;
      byh_q    <= 1'b0;
      used_q   <= '0;
      nh_q     <= 16'd1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      iss_q    <= iss_d;
      chk_q    <= chk_d;
      fi_q     <= fi_d;
      w_q      <= w_d;
      rv_q     <= rv_d;
      found_q  <= found_d;
      cv_q     <= cv_d;
      byh_q    <= byh_d;
      used_q   <= used_d;
      nh_q     <= nh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    key_q    <= key_d;
    owner_q  <= owner_d;
    fe_q     <= fe_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    bytes_q  <= bytes_d;
    total_q  <= total_d;
    hout_q   <= hout_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign req_ready_o = (state_q == S_IDLE) && !rebuild_i;
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = '{status: status_q, granted_addr: addr_q, granted_bytes: bytes_q,
                         granted_handle: hout_q, bytes_used: used_q,
                         pool_total: total_q};

endmodule

// ===== design/first_fit_block_allocator_unit.sv =====
// top level of the first-fit block allocator: config registers, table ram, result register
// Each request beat is served one at a time from a block table held in a
// single-port-write ram with a registered read; the table walk is the
// limiting loop. An allocation scans the table for the first free entry that
// fits, shifts the later entries up when that entry is split, and writes the
// granted entry; a free walks the whole table and merges free neighbours; an
// info request needs no walk. The table holds up to 64 entries. After each
// result the sequencer returns to idle before the next request beat is taken.
// A config write to the pool base or size rebuilds the table, and no request
// beat is taken during the rebuild. The result beat sits in an output
// register so the next request can start while it waits.
module first_fit_block_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,   // request_bytes, owner_id, block_handle
  input  logic [1:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // status, granted_addr, granted_bytes,
                                       // granted_handle, bytes_used, pool_total
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import ffba_pkg::*;

  logic [31:0] pool_base_q, pool_bytes_q;
  logic        out_valid_q;
  res_t        out_q;
  logic        idle, cfg_fire, rebuild;
  logic        res_valid, res_ready;
  res_t        res;
  req_t        req;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  assign cfg_ready_o = idle;
  assign cfg_fire    = cfg_valid_i && idle;
  assign rebuild     = cfg_fire && (cfg_index_i == REG_POOL_BASE ||
                                    cfg_index_i == REG_POOL_BYTES);

  assign req = '{mode: s_axis_tuser, request_bytes: s_axis_tdata[31:0],
                 owner_id: s_axis_tdata[36:32], block_handle: s_axis_tdata[52:37]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_bytes_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_fire && cfg_index_i == REG_POOL_BASE) begin
        pool_base_q <= cfg_data_i;
      end
      if (cfg_fire && cfg_index_i == REG_POOL_BYTES) begin
        pool_bytes_q <= cfg_data_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign res_ready     = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.pool_total, out_q.bytes_used, out_q.granted_handle,
                          out_q.granted_bytes, out_q.granted_addr, out_q.status};

  ffba_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ffba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_i        (req),
    .rebuild_i    (rebuild),
    .idle_o       (idle),
    .pool_base_i  (pool_base_q),
    .pool_bytes_i (pool_bytes_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

endmodule

// ===== sim/tb_first_fit_block_allocator_unit.sv =====
// testbench of the first-fit block allocator: random and directed requests against a table predictor
module tb_first_fit_block_allocator_unit;
  import ffba_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  class alloc_scoreboard;
    logic [31:0] base_reg, bytes_reg;
    entry_t      tbl [MAX_BLOCKS];
    int          cnt;
    logic [31:0] used;
    logic [15:0] hnext;
    res_t        pending [$];
    int          errors;

    function void rebuild();
      logic [32:0] b;
      logic [32:0] offs;
      logic [32:0] len;
      b    = ({1'b0, base_reg} + GRAN_MASK) & ~GRAN_MASK;
      offs = b - {1'b0, base_reg};
      len  = '0;
      if (!b[32] && offs < {1'b0, bytes_reg}) begin
        len = {1'b0, bytes_reg} - offs;
        if ({1'b0, b} + {1'b0, len} > 34'h100000000) len = 33'h100000000 - b;
      end
      foreach (tbl[i]) tbl[i] = '0;
      tbl[0].start  = b[31:0];
      tbl[0].length = len[31:0];
      cnt  = 1;
      used = '0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == REG_POOL_BASE) base_reg = val;
      else if (idx == REG_POOL_BYTES) bytes_reg = val;
      else return;
      rebuild();
    endfunction

    function void clear();
      base_reg = '0; bytes_reg = '0; hnext = 16'd1; errors = 0;
      rebuild();
    endfunction

    function void coalesce();
      int w;
      w = 0;
      for (int r = 0; r < cnt; r++) begin
        if (w > 0 && !tbl[w-1].in_use && !tbl[r].in_use)
          tbl[w-1].length += tbl[r].length;
        else begin
          tbl[w] = tbl[r];
          w++;
        end
      end
      cnt = w;
    endfunction

    function logic [1:0] release_blocks(bit by_handle, logic [15:0] key);
      bit found;
      found = 0;
      if (key == 0) return ST_NOTFOUND;
      for (int i = 0; i < cnt; i++) begin
        if (tbl[i].in_use &&
            (by_handle ? tbl[i].handle == key : tbl[i].owner == key[4:0])) begin
          tbl[i].in_use = 0; tbl[i].owner = '0; tbl[i].handle = '0;
          used -= tbl[i].length;
          found = 1;
          if (by_handle) break;
        end
      end
      if (found) coalesce();
      return found ? ST_OK : ST_NOTFOUND;
    endfunction

    function void grant(logic [31:0] req, logic [4:0] own, ref res_t r);
      logic [32:0] rs;
      logic [31:0] sz;
      int i;
      rs = ({1'b0, req} + GRAN_MASK) & ~GRAN_MASK;
      r.status = ST_NOFIT;
      if (rs == 0 || rs[32]) return;
      sz = rs[31:0];
      for (i = 0; i < cnt; i++)
        if (!tbl[i].in_use && tbl[i].length >= sz) break;
      if (i >= cnt) return;
      if (tbl[i].length > sz) begin
        if (cnt >= MAX_BLOCKS) begin
          r.status = ST_FULL;
          return;
        end
        for (int k = cnt; k > i; k--) tbl[k] = tbl[k-1];
        cnt++;
        tbl[i+1].start  = tbl[i].start + sz;
        tbl[i+1].length = tbl[i].length - sz;
        tbl[i].length   = sz;
      end
      tbl[i].in_use = 1; tbl[i].owner = own; tbl[i].handle = hnext;
      used += sz;
      r.status = ST_OK; r.granted_addr = tbl[i].start;
      r.granted_bytes = sz; r.granted_handle = hnext;
      hnext = hnext + 16'd1;
      if (hnext == 0) hnext = 16'd1;
    endfunction

    function void note_request(req_t q);
      res_t r;
      r = '0;
      case (q.mode)
        MODE_ALLOC: grant(q.request_bytes, q.owner_id, r);
        MODE_FREEH: r.status = release_blocks(1, q.block_handle);
        MODE_FREEO: r.status = release_blocks(0, {11'd0, q.owner_id});
        default:    r.pool_total = bytes_reg;
      endcase
      r.bytes_used = used;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.granted_addr != exp.granted_addr)
        $display("%0t: addr exp %h got %h", $time, exp.granted_addr, got.granted_addr);
      if (got.granted_bytes != exp.granted_bytes)
        $display("%0t: bytes exp %h got %h", $time, exp.granted_bytes, got.granted_bytes);
      if (got.granted_handle != exp.granted_handle)
        $display("%0t: handle exp %h got %h", $time, exp.granted_handle,
                 got.granted_handle);
      if (got.bytes_used != exp.bytes_used)
        $display("%0t: used exp %h got %h", $time, exp.bytes_used, got.bytes_used);
      if (got.pool_total != exp.pool_total)
        $display("%0t: total exp %h got %h", $time, exp.pool_total, got.pool_total);
      if (got != exp) errors++;
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;  // request_bytes, owner_id, block_handle
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [151:0] m_axis_tdata;       // status, addr, bytes, handle, used, total
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  first_fit_block_allocator_unit dut (.*);

  alloc_scoreboard sb = new();
  int  cycles = 0;
  bit  no_idle = 0;
  int  idle_pct = 28;

  function automatic res_t unpack_res(logic [151:0] d);
    res_t r;
    r.status         = d[1:0];
    r.granted_addr   = d[33:2];
    r.granted_bytes  = d[65:34];
    r.granted_handle = d[81:66];
    r.bytes_used     = d[113:82];
    r.pool_total     = d[145:114];
    return r;
  endfunction

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: sample at rising edge, stall at random on the falling edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(unpack_res(m_axis_tdata));

  always @(negedge clk_i)
    m_axis_tready <= no_idle || ($urandom_range(99) >= idle_pct);

  task automatic write_cfg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic send(logic [1:0] m, logic [31:0] rq, logic [4:0] own, logic [15:0] h);
    req_t q;
    q = '{mode: m, request_bytes: rq, owner_id: own, block_handle: h};
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {3'd0, h, own, rq};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(q);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1);
      2:       return 32'hFFFFF000 + $urandom_range(4095);
      default: return $urandom_range(40000);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(99) < 55) ? MODE_ALLOC : 2'($urandom_range(3));
      send(m, rand_size(), 5'($urandom_range(7) == 0 ? $urandom_range(31)
                                                      : $urandom_range(4)),
           ($urandom_range(9) == 0) ? 16'($urandom)
                                    : sb.hnext - 16'($urandom_range(12)));
    end
  endtask

  initial begin
    sb.clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // empty pool after reset, then extremes of each field
    send(MODE_INFO, '0, '0, '0);
    send(MODE_ALLOC, 32'd1, 5'd1, '0);
    drain();
    write_cfg(REG_POOL_BASE, 32'h1000_0001);
    write_cfg(REG_POOL_BYTES, 32'h0004_0000);
    send(MODE_ALLOC, 32'd0, 5'd1, '0);
    send(MODE_ALLOC, 32'hFFFF_FFFF, 5'd31, '0);
    send(MODE_ALLOC, 32'hFFFF_F001, 5'd1, '0);
    send(MODE_ALLOC, 32'd1, 5'd31, '0);
    send(MODE_ALLOC, 32'd4096, 5'd2, '0);
    send(MODE_ALLOC, 32'd8193, 5'd31, '0);
    send(MODE_FREEH, '0, '0, 16'd0);
    send(MODE_FREEH, '0, '0, 16'hFFFF);
    send(MODE_FREEH, '0, '0, sb.hnext - 16'd2);
    send(MODE_FREEO, '0, 5'd0, '0);
    send(MODE_FREEO, '0, 5'd31, '0);
    send(MODE_ALLOC, 32'h0003_0000, 5'd3, '0);
    send(MODE_INFO, 32'hFFFF_FFFF, 5'd31, 16'hFFFF);
    send(MODE_FREEO, '0, 5'd1, '0);
    // allocate a run of small blocks of one granule each
    for (int i = 0; i < 8; i++) send(MODE_ALLOC, 32'd4096, 5'd4, '0);
    drain();

    write_cfg(REG_POOL_BYTES, 32'h0010_0000);
    for (int i = 0; i < 70; i++) send(MODE_ALLOC, 32'd1, 5'($urandom_range(1, 3)), '0);
    random_phase(250);
    drain();

    // pool near the top of the address space
    write_cfg(REG_POOL_BASE, 32'hFFF0_0000);
    write_cfg(REG_POOL_BYTES, 32'hFFFF_FFFF);
    no_idle = 1;
    random_phase(120);
    no_idle = 0;
    drain();

    write_cfg(REG_POOL_BASE, 32'hFFFF_FFFF);
    send(MODE_ALLOC, 32'd1, 5'd1, '0);
    send(MODE_INFO, '0, '0, '0);
    drain();

    write_cfg(REG_POOL_BASE, 32'h0000_0000);
    write_cfg(REG_POOL_BYTES, 32'hFFFF_FFFF);
    random_phase(150);
    drain();

    write_cfg(REG_POOL_BASE, $urandom);
    write_cfg(REG_POOL_BYTES, 32'h0000_8000 + $urandom_range(32'h0004_0000));
    random_phase(250);
    send(MODE_INFO, '0, '0, '0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ===== first_fit_block_allocator_unit.f =====
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator_unit.sv
sim/tb_first_fit_block_allocator_unit.sv
